### design/psev_pkg.sv
// shared types and constants for the postfix stack evaluator
package psev_pkg;

  localparam int DataW      = 32;
  localparam int StackDepth = 64;
  localparam int CountW     = $clog2(StackDepth + 1);
  localparam int AddrW      = $clog2(StackDepth);
  localparam int DepthW     = 7;
  localparam int StepW      = $clog2(DataW);

  typedef enum logic [2:0] {
    OP_PUSH = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_NEG  = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_FULL = 2'd2,
    ST_DIVZ = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_LOAD,
    SEQ_WAIT
  } seq_state_e;

  typedef enum logic [1:0] {
    ALU_IDLE,
    ALU_DIV,
    ALU_SIGN
  } alu_state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [DataW-1:0] result;
  } alu_rsp_t;

endpackage

### design/postfix_stack_evaluator_top.sv
// postfix stack evaluator top level: operand stack, sequencer and output register
// Usage: each input item (op_i, value_i) is one postfix operation on a 64-entry
// stack of 32-bit signed values: push, add, subtract, multiply, divide, negate.
// Every accepted item gives exactly one result item: the new top value (zero
// when empty), the depth, an empty flag and a status (ok, too few operands,
// stack full, divide by zero). On any error the stack is unchanged.
// Both channels use valid/stall; an item moves when valid is high and stall low.
// Push, negate, errors and unused op codes give their result in the cycle after
// acceptance. Add, subtract and multiply pass through the stack memory read
// register, the shared arithmetic unit and the output register. Divide goes
// through the bit-serial divider, which does one quotient bit per cycle.
// One item is worked on at a time; in_stall_o is high while an item is in
// flight and while a result is held in the output register under out_stall_i.
// The top of stack lives in a register, the entries below it in a memory.
// Reset empties the stack and clears the output register valid; no clearing
// pass is needed since only written entries are ever read.
module postfix_stack_evaluator_top import psev_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              op_i,
  input  logic signed [DataW-1:0] value_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [DataW-1:0] top_value_o,
  output logic [DepthW-1:0]       depth_o,
  output logic                    is_empty_o,
  output logic [1:0]              status_o
);

  logic [DataW-1:0] mem [StackDepth];
  logic [DataW-1:0] rd_data_q;
  logic             mem_we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [CountW-1:0] count_m1, count_m2;

  seq_state_e        state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [DataW-1:0]  top_q, top_d;
  op_e               op_q, op_d;

  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  out_top_q, out_top_d;
  logic [DepthW-1:0] out_depth_q, out_depth_d;
  logic              out_empty_q, out_empty_d;
  status_e           out_status_q, out_status_d;

  alu_req_t alu_req;
  alu_rsp_t alu_rsp;

  logic    out_free, accept, emit;
  status_e status;

  assign count_m1 = count_q - CountW'(1);
  assign count_m2 = count_q - CountW'(2);
  assign wr_addr  = count_m1[AddrW-1:0];
  assign rd_addr  = count_m2[AddrW-1:0];

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[wr_addr] <= top_q;
    end
    rd_data_q <= mem[rd_addr];
  end

  psev_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .a_i    (rd_data_q),
    .b_i    (top_q),
    .rsp_o  (alu_rsp)
  );

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != SEQ_IDLE) || !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SEQ_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    top_q        <= top_d;
    op_q         <= op_d;
    out_top_q    <= out_top_d;
    out_depth_q  <= out_depth_d;
    out_empty_q  <= out_empty_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    top_d         = top_q;
    op_d          = op_q;
    mem_we        = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    emit          = 1'b0;
    status        = ST_OK;
    out_valid_d   = out_valid_q && out_stall_i;
    out_top_d     = out_top_q;
    out_depth_d   = out_depth_q;
    out_empty_d   = out_empty_q;
    out_status_d  = out_status_q;

    unique case (state_q)
      SEQ_IDLE: begin
        if (accept) begin
          op_d = op_e'(op_i);
          emit = 1'b1;
          unique case (op_e'(op_i))
            OP_PUSH: begin
              if (count_q == CountW'(StackDepth)) begin
                status = ST_FULL;
              end else begin
                mem_we  = (count_q != '0);
                top_d   = value_i;
                count_d = count_q + CountW'(1);
              end
            end
            OP_NEG: begin
              if (count_q == '0) begin
                status = ST_FEW;
              end else begin
                top_d = DataW'(0) - top_q;
              end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
              if (count_q < CountW'(2)) begin
                status = ST_FEW;
              end else if ((op_e'(op_i) == OP_DIV) && (top_q == '0)) begin
                status = ST_DIVZ;
              end else begin
                emit    = 1'b0;
                state_d = SEQ_LOAD;
              end
            end
            default: begin
              status = ST_OK;
            end
          endcase
        end
      end
      SEQ_LOAD: begin
        alu_req.start = 1'b1;
        state_d       = SEQ_WAIT;
      end
      SEQ_WAIT: begin
        if (alu_rsp.done && out_free) begin
          top_d   = alu_rsp.result;
          count_d = count_m1;
          emit    = 1'b1;
          state_d = SEQ_IDLE;
        end
      end
      default: begin
        state_d = SEQ_IDLE;
      end
    endcase

    if (emit) begin
      out_valid_d  = 1'b1;
      out_top_d    = (count_d != '0) ? top_d : '0;
      out_depth_d  = DepthW'(count_d);
      out_empty_d  = (count_d == '0);
      out_status_d = status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign top_value_o = out_top_q;
  assign depth_o     = out_depth_q;
  assign is_empty_o  = out_empty_q;
  assign status_o    = out_status_q;

`ifndef NO_ASSERTIONS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(StackDepth))
    else $error("stack count above capacity");

  a_busy_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != SEQ_IDLE) |-> in_stall_o)
    else $error("input not stalled while an item is in flight");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (is_empty_o == (depth_o == '0)))
    else $error("empty flag disagrees with depth");

  a_divz_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == ST_DIVZ)) |-> (depth_o >= DepthW'(2)))
    else $error("divide by zero reported with fewer than two entries");

  a_alu_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SEQ_LOAD) |=> (state_q == SEQ_WAIT))
    else $error("sequencer skipped the arithmetic wait");
`endif

endmodule

### design/psev_alu.sv
// shared arithmetic unit: add, subtract and multiply with a registered result, divide bit-serially
module psev_alu import psev_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alu_req_t         req_i,
  input  logic [DataW-1:0] a_i,
  input  logic [DataW-1:0] b_i,
  output alu_rsp_t         rsp_o
);

  alu_state_e       state_q, state_d;
  logic             done_q, done_d;
  logic [DataW-1:0] result_q, result_d;
  logic [DataW-1:0] rem_q, rem_d;
  logic [DataW-1:0] quo_q, quo_d;
  logic [DataW-1:0] den_q, den_d;
  logic             neg_q, neg_d;
  logic [StepW-1:0] step_q, step_d;

  logic [DataW-1:0] mag_a, mag_b, shifted;
  logic [DataW:0]   trial;

  assign mag_a   = a_i[DataW-1] ? (DataW'(0) - a_i) : a_i;
  assign mag_b   = b_i[DataW-1] ? (DataW'(0) - b_i) : b_i;
  assign shifted = {rem_q[DataW-2:0], quo_q[DataW-1]};
  assign trial   = {1'b0, shifted} - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ALU_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    den_q    <= den_d;
    neg_q    <= neg_d;
    step_q   <= step_d;
  end

  always_comb begin
    state_d  = state_q;
    done_d   = done_q;
    result_d = result_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    den_d    = den_q;
    neg_d    = neg_q;
    step_d   = step_q;
    unique case (state_q)
      ALU_IDLE: begin
        if (req_i.start) begin
          unique case (req_i.op)
            OP_ADD: begin
              result_d = a_i + b_i;
              done_d   = 1'b1;
            end
            OP_SUB: begin
              result_d = a_i - b_i;
              done_d   = 1'b1;
            end
            OP_MUL: begin
              result_d = a_i * b_i;
              done_d   = 1'b1;
            end
            OP_DIV: begin
              rem_d   = '0;
              quo_d   = mag_a;
              den_d   = mag_b;
              neg_d   = a_i[DataW-1] ^ b_i[DataW-1];
              step_d  = '0;
              done_d  = 1'b0;
              state_d = ALU_DIV;
            end
            default: begin
              result_d = a_i;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      ALU_DIV: begin
        if (!trial[DataW]) begin
          rem_d = trial[DataW-1:0];
          quo_d = {quo_q[DataW-2:0], 1'b1};
        end else begin
          rem_d = shifted;
          quo_d = {quo_q[DataW-2:0], 1'b0};
        end
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(DataW - 1)) begin
          state_d = ALU_SIGN;
        end
      end
      ALU_SIGN: begin
        result_d = neg_q ? (DataW'(0) - quo_q) : quo_q;
        done_d   = 1'b1;
        state_d  = ALU_IDLE;
      end
      default: begin
        state_d = ALU_IDLE;
      end
    endcase
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = result_q;

endmodule

### sim/postfix_stack_evaluator_checker.sv
// checker for the postfix stack evaluator: operand stack predictor and result compare
module postfix_stack_evaluator_checker import psev_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        op_i,
  input  logic [DataW-1:0]  value_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [DataW-1:0]  top_value_i,
  input  logic [DepthW-1:0] depth_i,
  input  logic              is_empty_i,
  input  logic [1:0]        status_i,
  output int                fail_count_o,
  output int                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [DataW-1:0]  top_value;
    logic [DepthW-1:0] depth;
    logic              is_empty;
    status_e           status;
  } stack_outcome_t;

  logic [DataW-1:0] operand_mem [StackDepth];
  int unsigned      operand_count = 0;
  stack_outcome_t   outcome_q [$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count_o++;
  endtask

  function automatic stack_outcome_t apply_postfix_op(input logic [2:0] op,
                                                      input logic [DataW-1:0] operand);
    stack_outcome_t   res;
    logic [DataW-1:0] upper;
    logic [DataW-1:0] lower;
    logic [DataW-1:0] num_mag;
    logic [DataW-1:0] den_mag;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] combined;
    logic             folds;
    res.status = ST_OK;
    upper      = '0;
    lower      = '0;
    combined   = '0;
    folds      = 1'b0;
    if (operand_count >= 2) begin
      upper = operand_mem[operand_count-1];
      lower = operand_mem[operand_count-2];
    end
    case (op)
      OP_PUSH: begin
        if (operand_count >= StackDepth) begin
          res.status = ST_FULL;
        end else begin
          operand_mem[operand_count] = operand;
          operand_count++;
        end
      end
      OP_NEG: begin
        if (operand_count < 1) begin
          res.status = ST_FEW;
        end else begin
          operand_mem[operand_count-1] = -operand_mem[operand_count-1];
        end
      end
      OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
        if (operand_count < 2) begin
          res.status = ST_FEW;
        end else begin
          folds = 1'b1;
          case (op)
            OP_ADD: combined = lower + upper;
            OP_SUB: combined = lower - upper;
            OP_MUL: combined = lower * upper;
            default: begin
              if (upper == '0) begin
                folds      = 1'b0;
                res.status = ST_DIVZ;
              end else begin
                num_mag  = lower[DataW-1] ? -lower : lower;
                den_mag  = upper[DataW-1] ? -upper : upper;
                quo      = num_mag / den_mag;
                combined = (lower[DataW-1] ^ upper[DataW-1]) ? -quo : quo;
              end
            end
          endcase
          if (folds) begin
            operand_mem[operand_count-2] = combined;
            operand_count--;
          end
        end
      end
      default: ;
    endcase
    res.top_value = (operand_count > 0) ? operand_mem[operand_count-1] : '0;
    res.depth     = DepthW'(operand_count);
    res.is_empty  = (operand_count == 0);
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    stack_outcome_t want;
    if (!rst_ni) begin
      operand_count = 0;
      outcome_q.delete();
      pending_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (outcome_q.size() == 0) begin
          report_mismatch($sformatf("result with no item pending: top %h depth %0d status %0d",
                                    top_value_i, depth_i, status_i));
        end else begin
          want = outcome_q.pop_front();
          if (top_value_i !== want.top_value)
            report_mismatch($sformatf("top value %h, expected %h", top_value_i, want.top_value));
          if (depth_i !== want.depth)
            report_mismatch($sformatf("depth %0d, expected %0d", depth_i, want.depth));
          if (is_empty_i !== want.is_empty)
            report_mismatch($sformatf("empty flag %b, expected %b", is_empty_i, want.is_empty));
          if (status_i !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d", status_i, want.status));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        outcome_q.push_back(apply_postfix_op(op_i, value_i));
      end
      pending_o = outcome_q.size();
    end
  end

endmodule

### sim/tb_postfix_stack_evaluator_top.sv
// testbench top for the postfix stack evaluator: clock, reset, stimulus and verdict
module tb_postfix_stack_evaluator_top import psev_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0]       OpUnusedLo  = 3'd6;
  localparam logic [2:0]       OpUnusedHi  = 3'd7;
  localparam logic [DataW-1:0] MaxVal      = 32'h7FFF_FFFF;
  localparam logic [DataW-1:0] MinVal      = 32'h8000_0000;
  localparam logic [DataW-1:0] AllOnes     = '1;
  localparam int               RandomItems = 1000;
  localparam int               QuietItems  = 150;
  localparam int               DrainCycles = 40;
  localparam int unsigned      CycleLimit  = 500000;

  logic                    clk       = 1'b0;
  logic                    rst_n     = 1'b0;
  logic                    in_valid  = 1'b0;
  logic [2:0]              in_op     = '0;
  logic signed [DataW-1:0] in_value  = '0;
  logic                    out_stall = 1'b0;
  logic                    in_stall;
  logic                    out_valid;
  logic signed [DataW-1:0] top_value;
  logic [DepthW-1:0]       depth;
  logic                    is_empty;
  logic [1:0]              status;
  int                      fail_count;
  int                      pending;
  logic                    idling_on   = 1'b0;
  int                      stall_left  = 0;
  int unsigned             cycle_count = 0;

  always #5 clk = ~clk;

  postfix_stack_evaluator_top u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .op_i        (in_op),
    .value_i     (in_value),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .top_value_o (top_value),
    .depth_o     (depth),
    .is_empty_o  (is_empty),
    .status_o    (status)
  );

  postfix_stack_evaluator_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .op_i         (in_op),
    .value_i      (in_value),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .top_value_i  (top_value),
    .depth_i      (depth),
    .is_empty_i   (is_empty),
    .status_i     (status),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 7);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_item(input logic [2:0] op_code, input logic [DataW-1:0] operand);
    int gap;
    if (idling_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op    <= op_code;
    in_value <= operand;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  function automatic logic [DataW-1:0] pick_operand();
    int small_val;
    small_val = int'($urandom_range(0, 40)) - 20;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0:       return '0;
          1:       return 1;
          2:       return AllOnes;
          3:       return MinVal;
          default: return MaxVal;
        endcase
      end
      1, 2, 3: return DataW'(small_val);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int         seg_left;
    int         push_pct;
    logic [2:0] next_op;
    seg_left = 0;
    push_pct = 50;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_item(OP_ADD, '0);
    send_item(OP_NEG, AllOnes);
    send_item(OpUnusedLo, MaxVal);
    send_item(OpUnusedHi, MinVal);
    send_item(OP_DIV, '0);
    send_item(OP_PUSH, MaxVal);
    send_item(OP_ADD, 1);
    send_item(OP_PUSH, MinVal);
    send_item(OP_ADD, '0);
    send_item(OP_PUSH, '0);
    send_item(OP_DIV, AllOnes);
    send_item(OP_SUB, '0);
    send_item(OP_NEG, '0);
    send_item(OP_PUSH, MinVal);
    send_item(OP_NEG, '0);
    send_item(OP_MUL, '0);
    send_item(OP_PUSH, AllOnes);
    send_item(OP_DIV, '0);
    send_item(OP_PUSH, 7);
    send_item(OP_PUSH, -2);
    send_item(OP_DIV, '0);
    send_item(OP_SUB, '0);
    send_item(OP_PUSH, MaxVal);
    send_item(OP_MUL, '0);
    send_item(OP_NEG, $urandom);
    wait_for_drain();

    for (int i = 0; i < RandomItems; i++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(40, 100);
        case ($urandom_range(0, 2))
          0:       push_pct = 90;
          1:       push_pct = 25;
          default: push_pct = 55;
        endcase
        idling_on <= (i < RandomItems - QuietItems) && ($urandom_range(0, 3) != 0);
      end else if (i >= RandomItems - QuietItems) begin
        idling_on <= 1'b0;
      end
      seg_left--;
      if ($urandom_range(0, 19) == 0) begin
        next_op = 3'($urandom_range(OpUnusedLo, OpUnusedHi));
      end else if ($urandom_range(0, 99) < push_pct) begin
        next_op = OP_PUSH;
      end else begin
        next_op = 3'($urandom_range(OP_ADD, OP_NEG));
      end
      send_item(next_op, pick_operand());
      if (i == RandomItems / 2) wait_for_drain();
    end

    wait_for_drain();
    repeat (DrainCycles) @(negedge clk);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### postfix_stack_evaluator_top.f
design/psev_pkg.sv
design/psev_alu.sv
design/postfix_stack_evaluator_top.sv
sim/postfix_stack_evaluator_checker.sv
sim/tb_postfix_stack_evaluator_top.sv
